/* design/ddodo_pkg.sv */
// ----------------------------------------------------------------------------
// ddodo_pkg
// Shared types and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddodo_pkg;

   // configuration register indexes
   localparam logic REG_HEADING_GAIN    = 1'b0;
   localparam logic REG_INV_TRACK_WIDTH = 1'b1;

   localparam logic [31:0] HEADING_GAIN_RST    = 32'd2278550919;
   localparam logic [23:0] INV_TRACK_WIDTH_RST = 24'd218453;

   // reciprocal of the cordic gain, 2^-32 units
   localparam logic [31:0] CORDIC_K = 32'd2608131496;

   // arctangent of 2^-i, 2^32 units per turn, rounded
   localparam int unsigned ATAN_DEPTH = 32;
   localparam int unsigned ITER_W     = $clog2(ATAN_DEPTH);
   localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef enum logic [1:0] {
      MUL_ANG,
      MUL_HDG,
      MUL_STEP
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        prep;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        ang_load;
      logic        hdg_load;
      logic        cordic_init;
      logic        cordic_iter;
      logic        pose_update;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic primed;
      logic iter_last;
      logic out_busy;
   } sts_type;

   // clamp to 32 bits signed
   function automatic logic [31:0] sat32(input logic signed [47:0] v);
      logic [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -48'sh0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* design/ddodo_ctrl.sv */
// ----------------------------------------------------------------------------
// ddodo_ctrl
// Sequencer of one odometry update: multiplies, cordic loop, pose update.
// ----------------------------------------------------------------------------
module ddodo_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ddodo_pkg::sts_type sts,
   output ddodo_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MANG  = 3'd1;
   localparam logic [2:0] S_MHDG  = 3'd2;
   localparam logic [2:0] S_MSTEP = 3'd3;
   localparam logic [2:0] S_CINIT = 3'd4;
   localparam logic [2:0] S_CITER = 3'd5;
   localparam logic [2:0] S_ACC   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = ddodo_pkg::MUL_ANG;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_MANG;
            end
         end
         S_MANG: begin
            cmd.prep    = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ddodo_pkg::MUL_ANG;
            state_in    = S_MHDG;
         end
         S_MHDG: begin
            cmd.ang_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = ddodo_pkg::MUL_HDG;
            // first beat after reset only stores the distances
            state_in     = sts.primed ? S_MSTEP : S_DONE;
         end
         S_MSTEP: begin
            cmd.hdg_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = ddodo_pkg::MUL_STEP;
            state_in     = S_CINIT;
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            state_in        = S_CITER;
         end
         S_CITER: begin
            cmd.cordic_iter = 1'b1;
            if (sts.iter_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.pose_update = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/ddodo_dp.sv */
// ----------------------------------------------------------------------------
// ddodo_dp
// Odometry datapath: config registers, shared multiplier, iterative cordic,
// saturating position and wrapping heading accumulators and the result register.
// ----------------------------------------------------------------------------
module ddodo_dp #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [31:0]          csr_wdata,
   input  logic [127:0]         req_tdata,
   input  ddodo_pkg::cmd_type   cmd,
   output ddodo_pkg::sts_type   sts,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [159:0]         rsp_tdata
);

   localparam int XW = 50;
   localparam int ZW = 34;

   logic [31:0] gain_ff;
   logic [23:0] inv_ff;

   logic [31:0] last_left_ff;
   logic [31:0] last_right_ff;
   logic        primed_ff;
   logic        item_primed_ff;

   logic [31:0]        dl_ff;
   logic [31:0]        dr_ff;
   logic signed [32:0] spd_diff_ff;
   logic [31:0]        lin_ff;
   logic signed [32:0] diff_ff;
   logic [31:0]        step_ff;

   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_full;
   logic [63:0]        prod_ff;

   logic [31:0] ang_ff;
   logic [31:0] dth_ff;
   logic [31:0] mid_ff;

   logic signed [XW-1:0]   x_ff;
   logic signed [XW-1:0]   y_ff;
   logic signed [ZW-1:0]   z_ff;
   logic [ddodo_pkg::ITER_W-1:0] cnt_ff;

   logic [31:0] pos_x_ff;
   logic [31:0] pos_y_ff;
   logic [31:0] heading_ff;

   logic         rsp_valid_ff;
   logic [159:0] rsp_data_ff;

   // input fields
   logic [31:0]        in_left;
   logic [31:0]        in_right;
   logic signed [32:0] in_ls;
   logic signed [32:0] in_rs;
   logic signed [32:0] lin_sum;
   logic signed [32:0] dsum;

   // cordic helpers
   logic signed [XW-1:0] x0;
   logic                 flip;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [ZW-1:0] at;
   logic signed [47:0]   px_sum;
   logic signed [47:0]   py_sum;

   assign in_left  = req_tdata[31:0];
   assign in_right = req_tdata[63:32];
   assign in_ls    = $signed({req_tdata[95], req_tdata[95:64]});
   assign in_rs    = $signed({req_tdata[127], req_tdata[127:96]});
   assign lin_sum  = in_ls + in_rs;
   assign dsum     = $signed({dl_ff[31], dl_ff}) + $signed({dr_ff[31], dr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= ddodo_pkg::HEADING_GAIN_RST;
         inv_ff  <= ddodo_pkg::INV_TRACK_WIDTH_RST;
      end else if (csr_we) begin
         if (csr_addr == ddodo_pkg::REG_HEADING_GAIN) begin
            gain_ff <= csr_wdata;
         end
         if (csr_addr == ddodo_pkg::REG_INV_TRACK_WIDTH) begin
            inv_ff <= csr_wdata[23:0];
         end
      end
   end

   // capture beat: distance steps wrap to 32 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff   <= '0;
         last_right_ff  <= '0;
         primed_ff      <= 1'b0;
         item_primed_ff <= 1'b0;
      end else if (cmd.capture) begin
         last_left_ff   <= in_left;
         last_right_ff  <= in_right;
         primed_ff      <= 1'b1;
         item_primed_ff <= primed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dl_ff       <= in_left - last_left_ff;
         dr_ff       <= in_right - last_right_ff;
         spd_diff_ff <= in_rs - in_ls;
         lin_ff      <= lin_sum[32:1];
      end
      if (cmd.prep) begin
         diff_ff <= $signed({dr_ff[31], dr_ff}) - $signed({dl_ff[31], dl_ff});
         step_ff <= dsum[32:1];
      end
   end

   // shared signed multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         ddodo_pkg::MUL_ANG: begin
            mul_a = spd_diff_ff;
            mul_b = $signed({9'd0, inv_ff});
         end
         ddodo_pkg::MUL_HDG: begin
            mul_a = diff_ff;
            mul_b = $signed({1'b0, gain_ff});
         end
         ddodo_pkg::MUL_STEP: begin
            mul_a = $signed({step_ff[31], step_ff});
            mul_b = $signed({1'b0, ddodo_pkg::CORDIC_K});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_full[63:0];
      end
      if (cmd.ang_load) begin
         ang_ff <= ddodo_pkg::sat32($signed(prod_ff[63:16]));
      end
      if (cmd.hdg_load) begin
         dth_ff <= prod_ff[47:16];
         mid_ff <= heading_ff + prod_ff[48:17];
      end
   end

   // cordic, rotation mode, one iteration a cycle
   assign x0   = $signed({{(XW - 48){prod_ff[63]}}, prod_ff[63:16]});
   assign flip = ($signed(mid_ff) > 32'sd1073741824) || ($signed(mid_ff) < -32'sd1073741824);
   assign xs   = x_ff >>> cnt_ff;
   assign ys   = y_ff >>> cnt_ff;
   assign at   = $signed({{(ZW - 32){1'b0}}, ddodo_pkg::ATAN_TAB[cnt_ff]});

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         x_ff   <= flip ? -x0 : x0;
         y_ff   <= '0;
         // quadrant fold: turn by half a revolution
         z_ff   <= flip ? $signed({{(ZW - 31){~mid_ff[31]}}, mid_ff[30:0]})
                        : $signed({{(ZW - 32){mid_ff[31]}}, mid_ff});
         cnt_ff <= '0;
      end else if (cmd.cordic_iter) begin
         if (!z_ff[ZW-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign px_sum = $signed(pos_x_ff) + $signed(x_ff[XW-1:16]);
   assign py_sum = $signed(pos_y_ff) + $signed(y_ff[XW-1:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= '0;
      end else if (cmd.pose_update) begin
         pos_x_ff   <= ddodo_pkg::sat32(px_sum);
         pos_y_ff   <= ddodo_pkg::sat32(py_sum);
         heading_ff <= heading_ff + dth_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {ang_ff, lin_ff, heading_ff, pos_y_ff, pos_x_ff};
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign sts.primed    = item_primed_ff;
   assign sts.iter_last = (cnt_ff == ddodo_pkg::ITER_W'(CORDIC_STEPS - 1));
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

endmodule

/* design/differential_drive_odometry.sv */
// a new input beat is taken only after the previous result is loaded into the
// result register; the first beat after reset only stores distances
// the rate of beats is bounded by the iterative cordic loop and the shared
// multiplier, used three times per beat (twice on the first beat after reset)
// reset: synchronous, clears pose, heading, stored distances and primed flag
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose from cumulative wheel distances and wheel speeds.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left_distance, right_distance, left_speed, right_speed
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pose_x, pose_y, pose_heading, linear_speed, angular_speed
   output logic [159:0] rsp_tdata
);

   ddodo_pkg::cmd_type cmd;
   ddodo_pkg::sts_type sts;

   ddodo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ddodo_dp #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/ddodo_checker.sv */
// ----------------------------------------------------------------------------
// ddodo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddodo_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // one beat in flight at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new beat taken while busy");

endmodule

bind differential_drive_odometry ddodo_checker u_ddodo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the differential drive odometry block. Wheel readings
// go in through a driver with random gaps, results are taken with random
// stalls, and every result beat is compared field by field against a pose
// tracker kept in the bench, over several heading gain and track settings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ODO_ITERS = 24;

   // pose_x, pose_y, pose_heading, linear_speed, angular_speed (lowest first)
   typedef struct packed {
      logic [31:0] ang_speed;
      logic [31:0] lin_speed;
      logic [31:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } odo_beat_type;

   logic          clock;
   logic          reset       = 1'b1;
   logic          csr_we      = 1'b0;
   logic          csr_addr    = ddodo_pkg::REG_HEADING_GAIN;
   logic [31:0]   csr_wdata   = '0;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   // left_distance, right_distance, left_speed, right_speed
   logic [127:0]  req_tdata   = '0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   // pose_x, pose_y, pose_heading, linear_speed, angular_speed
   logic [159:0]  rsp_tdata;

   differential_drive_odometry #(
      .CORDIC_STEPS (ODO_ITERS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // bench copy of configuration and pose state
   logic [31:0]        cfg_gain      = ddodo_pkg::HEADING_GAIN_RST;
   logic [23:0]        cfg_inv_track = ddodo_pkg::INV_TRACK_WIDTH_RST;
   logic [31:0]        trk_left      = '0;
   logic [31:0]        trk_right     = '0;
   logic signed [31:0] trk_x         = '0;
   logic signed [31:0] trk_y         = '0;
   logic [31:0]        trk_heading   = '0;
   logic               trk_primed    = 1'b0;

   logic [127:0] pending_beats [$];
   odo_beat_type pose_expect [$];

   // generator odometer, so well-formed readings continue a trip
   logic [31:0]  odo_left  = '0;
   logic [31:0]  odo_right = '0;

   int unsigned  feed_gap  = 0;
   int unsigned  feed_run  = 0;
   int unsigned  drain_gap = 0;
   int unsigned  drain_run = 0;
   int unsigned  errors    = 0;
   odo_beat_type want;
   logic [159:0] want_bits;
   string        field_name [5] = '{"pose_x", "pose_y", "pose_heading",
                                    "linear_speed", "angular_speed"};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [31:0] clamp32(input longint v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // mostly short gaps, some long ones, and now and then a run with none
   function automatic int unsigned pick_gap(inout int unsigned run);
      int unsigned r;
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         run = $urandom_range(20, 100);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // dead-reckoning update for one wheel reading, returns the pose beat
   function automatic odo_beat_type advance_pose(input logic [127:0] d);
      logic [31:0]        l, r, dth, half, mid;
      logic signed [31:0] dl32, dr32, mid_s, lin32;
      longint             ls, rs, dl, dr, step, prod, x, y, z, xs, ys, ang;
      odo_beat_type       o;
      l  = d[31:0];
      r  = d[63:32];
      ls = longint'($signed(d[95:64]));
      rs = longint'($signed(d[127:96]));
      if (!trk_primed) begin
         trk_primed = 1'b1;
      end else begin
         dl32 = l - trk_left;
         dr32 = r - trk_right;
         dl   = longint'(dl32);
         dr   = longint'(dr32);
         step = (dl + dr) >>> 1;
         // wraps mod 2^64, only bits below 49 are used
         prod = (dr - dl) * longint'({32'b0, cfg_gain});
         dth  = prod[47:16];
         half = prod[48:17];
         mid  = trk_heading + half;
         x    = (step * longint'({32'b0, ddodo_pkg::CORDIC_K})) >>> 16;
         y    = '0;
         mid_s = mid;
         z    = longint'(mid_s);
         // fold the back half-plane onto the front one
         if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
            x     = -x;
            mid_s = mid + 32'h8000_0000;
            z     = longint'(mid_s);
         end
         for (int i = 0; i < ODO_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - longint'({32'b0, ddodo_pkg::ATAN_TAB[i]});
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + longint'({32'b0, ddodo_pkg::ATAN_TAB[i]});
            end
         end
         trk_x       = clamp32(longint'(trk_x) + (x >>> 16));
         trk_y       = clamp32(longint'(trk_y) + (y >>> 16));
         trk_heading = trk_heading + dth;
      end
      trk_left  = l;
      trk_right = r;
      lin32 = 32'((ls + rs) >>> 1);
      ang   = ((rs - ls) * longint'({40'b0, cfg_inv_track})) >>> 16;
      o.x         = trk_x;
      o.y         = trk_y;
      o.heading   = trk_heading;
      o.lin_speed = lin32;
      o.ang_speed = clamp32(ang);
      return o;
   endfunction

   task automatic queue_reading(input logic [31:0] l, input logic [31:0] r,
                                input logic [31:0] ls, input logic [31:0] rs);
      odo_left  = l;
      odo_right = r;
      pending_beats.push_back({rs, ls, r, l});
   endtask

   task automatic queue_move(input logic [31:0] dl, input logic [31:0] dr,
                             input logic [31:0] ls, input logic [31:0] rs);
      queue_reading(odo_left + dl, odo_right + dr, ls, rs);
   endtask

   task automatic queue_trip(input int unsigned count);
      int unsigned sel;
      logic [31:0] fwd, turn, dl, dr, ls, rs;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if ($urandom_range(0, 1) == 0) begin
            ls = $urandom;
            rs = $urandom;
         end else begin
            ls = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            rs = ls + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         end
         if (sel < 8) begin
            // noise: readings unrelated to the previous ones
            queue_reading($urandom, $urandom, ls, rs);
         end else begin
            if (sel < 75) begin
               fwd  = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
               turn = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
               dl   = fwd - turn;
               dr   = fwd + turn;
            end else if (sel < 92) begin
               dl = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
               dr = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end else begin
               dl = $urandom;
               dr = $urandom;
            end
            queue_move(dl, dr, ls, rs);
         end
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_beats.size() != 0 || req_tvalid || pose_expect.size() != 0);
      repeat (ODO_ITERS + 16) @(posedge clock);
   endtask

   task automatic write_reg(input logic a, input logic [31:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      if (a == ddodo_pkg::REG_HEADING_GAIN) begin
         cfg_gain = v;
      end else begin
         cfg_inv_track = v[23:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // stimulus sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // first reading after reset only stores distances
      queue_reading(32'h1234_5678, 32'h9ABC_DEF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_move(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
      queue_move(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_move(32'hFFFF_8000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000);
      // mid-step heading past a quarter turn
      queue_move(32'h0003_0000, 32'h0005_0000, 32'h0, 32'hFFFF_FFFF);
      queue_move(32'h0006_0000, 32'h0001_0000, 32'h1, 32'h0);
      // counters roll over, one through the sign bit and one through zero
      queue_reading(32'h7FFF_FFF0, 32'hFFFF_FFF0, 32'h0001_0000, 32'h0002_0000);
      queue_move(32'h20, 32'h20, 32'h0002_0000, 32'h0001_0000);
      // largest steps forward and back, position saturates
      repeat (3) queue_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
      repeat (4) queue_move(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      queue_move(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      queue_move(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
      queue_move(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_reading(32'h0, 32'h0, 32'h0, 32'h0);
      queue_reading(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();

      // smallest nonzero gain, upper bits of the track reciprocal are dropped
      write_reg(ddodo_pkg::REG_HEADING_GAIN, 32'h0000_0001);
      write_reg(ddodo_pkg::REG_INV_TRACK_WIDTH, 32'hFF00_0001);
      queue_trip(286);
      wait_idle();

      write_reg(ddodo_pkg::REG_HEADING_GAIN, 32'hFFFF_FFFF);
      write_reg(ddodo_pkg::REG_INV_TRACK_WIDTH, 32'h00FF_FFFF);
      queue_trip(286);
      wait_idle();

      // zero registers give no heading or angular change
      write_reg(ddodo_pkg::REG_HEADING_GAIN, 32'h0);
      write_reg(ddodo_pkg::REG_INV_TRACK_WIDTH, 32'h0);
      queue_trip(286);
      wait_idle();

      write_reg(ddodo_pkg::REG_HEADING_GAIN, $urandom);
      write_reg(ddodo_pkg::REG_INV_TRACK_WIDTH, $urandom);
      queue_trip(286);
      wait_idle();

      write_reg(ddodo_pkg::REG_HEADING_GAIN, ddodo_pkg::HEADING_GAIN_RST);
      write_reg(ddodo_pkg::REG_INV_TRACK_WIDTH, {8'hA5, ddodo_pkg::INV_TRACK_WIDTH_RST});
      queue_trip(286);
      wait_idle();

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // input driver, predicts on every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pose_expect.push_back(advance_pose(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (feed_gap > 0) begin
               feed_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_tdata  <= pending_beats.pop_front();
               req_tvalid <= 1'b1;
               feed_gap = pick_gap(feed_run);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pose_expect.size() == 0) begin
               if (errors < 10) begin
                  $display("odometry: result beat with none pending, got %h", rsp_tdata);
               end
               errors++;
            end else begin
               want      = pose_expect.pop_front();
               want_bits = want;
               for (int i = 0; i < 5; i++) begin
                  if (want_bits[32*i +: 32] !== rsp_tdata[32*i +: 32]) begin
                     if (errors < 10) begin
                        $display("odometry: %s mismatch, expected %h got %h",
                                 field_name[i], want_bits[32*i +: 32],
                                 rsp_tdata[32*i +: 32]);
                     end
                     errors++;
                  end
               end
            end
            drain_gap = pick_gap(drain_run);
         end
         if (drain_gap > 0) begin
            drain_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

endmodule

/* files.f */
design/ddodo_pkg.sv
design/ddodo_ctrl.sv
design/ddodo_dp.sv
design/differential_drive_odometry.sv
design/ddodo_checker.sv
sim/tb_top.sv
